>>> hdl/nqpt_pkg.sv
// Shared types and codes for the NVMe queue pointer tracker.
// Used by nqpt_update and nvme_queue_pointer_tracker_core; no dependencies.
package nqpt_pkg;

  typedef enum logic [2:0] {
    KIND_CREATE_SQ = 3'd0,
    KIND_CREATE_CQ = 3'd1,
    KIND_DELETE_SQ = 3'd2,
    KIND_DELETE_CQ = 3'd3,
    KIND_SQ_DBELL  = 3'd4,
    KIND_CQ_DBELL  = 3'd5,
    KIND_SQ_ADV    = 3'd6,
    KIND_CQ_POST   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD_ID = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_e;

  localparam int unsigned QID_W   = 4;
  localparam int unsigned OUT_PTR_W = 16;

  // State updates decided for one command.
  typedef struct packed {
    logic is_cq;      // side addressed by the command
    logic entry_wr;   // write size/head/tail of the addressed queue
    logic valid_set;
    logic valid_clr;
    logic phase_wr;
    logic phase_val;
  } upd_t;

  typedef struct packed {
    status_e                status;
    logic                   sq_empty;
    logic                   cq_full;
    logic                   phase;
    logic [OUT_PTR_W-1:0]   head;
    logic [OUT_PTR_W-1:0]   tail;
  } result_t;

endpackage

>>> hdl/nvme_queue_pointer_tracker_core.sv
// Top level of the NVMe queue pointer tracker: handshakes, queue state storage.
// Depends on nqpt_pkg and nqpt_update.
//
//  Channel  Signals                                   Direction  Transfer when
//  in       in_valid_i/in_ready_o, kind/queue_id/value  in       valid & ready
//  out      out_valid_o/out_ready_i, status..tail      out       valid & ready
//  cfg      cfg_valid_i/cfg_ready_o, highest_queue_id  in       valid & ready
//
// One command per cycle is sustained while the output is not stalled. The input transfer
// edge also reads the queue entry memories into the stage; the result is registered when
// the staged command moves on. The entry memories have a registered read port; a write by
// the command ahead is forwarded into that read. Reset clears valid bits, sets all
// phase tags to one and needs no clearing pass. A stalled output holds the staged
// command, and the input side keeps taking commands only while the stage can move on.
module nvme_queue_pointer_tracker_core #(
  parameter int unsigned NUM_QUEUES = 16,
  parameter int unsigned PTR_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  queue_id_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        sq_empty_o,
  output logic        cq_full_o,
  output logic        phase_o,
  output logic [15:0] head_o,
  output logic [15:0] tail_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  highest_queue_id_i
);

  localparam int unsigned QIDX_W  = $clog2(NUM_QUEUES);
  localparam int unsigned EXT_W   = (QIDX_W > nqpt_pkg::QID_W) ? QIDX_W : nqpt_pkg::QID_W;
  localparam int unsigned ENTRY_W = 3 * PTR_WIDTH;

  logic [3:0]              hid_q;

  logic                    s_vld_q;
  nqpt_pkg::kind_e         s_kind_q;
  logic [QIDX_W-1:0]       s_idx_q;
  logic [15:0]             s_value_q;
  logic                    s_id_ok_q;
  logic [ENTRY_W-1:0]      sq_rd_q;
  logic [ENTRY_W-1:0]      cq_rd_q;

  logic [ENTRY_W-1:0]      sq_mem [NUM_QUEUES];
  logic [ENTRY_W-1:0]      cq_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]   sq_valid_q;
  logic [NUM_QUEUES-1:0]   cq_valid_q;
  logic [NUM_QUEUES-1:0]   cq_phase_q;

  logic                    out_vld_q;
  nqpt_pkg::result_t       res_q;

  logic                    in_xfer;
  logic                    s_adv;
  logic [EXT_W-1:0]        in_qid_ext;
  logic [QIDX_W-1:0]       in_idx;
  logic                    in_id_ok;
  logic                    sq_wr;
  logic                    cq_wr;

  nqpt_pkg::upd_t          upd;
  logic [ENTRY_W-1:0]      new_entry;
  nqpt_pkg::result_t       res;

  assign s_adv      = s_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s_vld_q || s_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_qid_ext = EXT_W'(queue_id_i);
  assign in_idx     = in_qid_ext[QIDX_W-1:0];
  assign in_id_ok   = (queue_id_i <= hid_q) && ({3'b000, queue_id_i} < 7'(NUM_QUEUES));

  assign sq_wr = s_adv && upd.entry_wr && !upd.is_cq;
  assign cq_wr = s_adv && upd.entry_wr && upd.is_cq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hid_q <= 4'hF;
    end else if (cfg_valid_i) begin
      hid_q <= highest_queue_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (in_xfer) begin
      s_vld_q <= 1'b1;
    end else if (s_adv) begin
      s_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s_kind_q  <= nqpt_pkg::kind_e'(kind_i);
      s_idx_q   <= in_idx;
      s_value_q <= value_i;
      s_id_ok_q <= in_id_ok;
    end
  end

  // Entry memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (sq_wr) begin
      sq_mem[s_idx_q] <= new_entry;
    end
    if (cq_wr) begin
      cq_mem[s_idx_q] <= new_entry;
    end
  end

  // The command leaving the stage commits on the same edge that this read happens,
  // so its write data is forwarded when both address the same queue.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sq_rd_q <= (sq_wr && s_idx_q == in_idx) ? new_entry : sq_mem[in_idx];
      cq_rd_q <= (cq_wr && s_idx_q == in_idx) ? new_entry : cq_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= '0;
      cq_valid_q <= '0;
      cq_phase_q <= '1;
    end else if (s_adv) begin
      if (upd.valid_set || upd.valid_clr) begin
        if (upd.is_cq) begin
          cq_valid_q[s_idx_q] <= upd.valid_set;
        end else begin
          sq_valid_q[s_idx_q] <= upd.valid_set;
        end
      end
      if (upd.phase_wr) begin
        cq_phase_q[s_idx_q] <= upd.phase_val;
      end
    end
  end

  nqpt_update #(
    .PTR_WIDTH (PTR_WIDTH)
  ) u_update (
    .kind_i     (s_kind_q),
    .id_ok_i    (s_id_ok_q),
    .sq_valid_i (sq_valid_q[s_idx_q]),
    .cq_valid_i (cq_valid_q[s_idx_q]),
    .phase_i    (cq_phase_q[s_idx_q]),
    .value_i    (s_value_q),
    .sq_entry_i (sq_rd_q),
    .cq_entry_i (cq_rd_q),
    .upd_o      (upd),
    .entry_o    (new_entry),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = res_q.status;
  assign sq_empty_o  = res_q.sq_empty;
  assign cq_full_o   = res_q.cq_full;
  assign phase_o     = res_q.phase;
  assign head_o      = res_q.head;
  assign tail_o      = res_q.tail;

endmodule

>>> hdl/nqpt_update.sv
// Command decode and pointer update for one queue entry.
// Combinational; depends on nqpt_pkg.
module nqpt_update #(
  parameter int unsigned PTR_WIDTH = 16
) (
  input  nqpt_pkg::kind_e          kind_i,
  input  logic                     id_ok_i,
  input  logic                     sq_valid_i,
  input  logic                     cq_valid_i,
  input  logic                     phase_i,
  input  logic [15:0]              value_i,
  input  logic [3*PTR_WIDTH-1:0]   sq_entry_i,
  input  logic [3*PTR_WIDTH-1:0]   cq_entry_i,
  output nqpt_pkg::upd_t           upd_o,
  output logic [3*PTR_WIDTH-1:0]   entry_o,
  output nqpt_pkg::result_t        res_o
);

  // Entry layout: {size, head, tail}.
  function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p,
                                                    input logic [PTR_WIDTH-1:0] size);
    logic [PTR_WIDTH:0] n;
    n = {1'b0, p} + (PTR_WIDTH+1)'(1);
    return (n >= {1'b0, size}) ? '0 : n[PTR_WIDTH-1:0];
  endfunction

  logic                 is_cq;
  logic                 slot_ok;
  logic                 report;
  logic                 nphase;
  logic [PTR_WIDTH-1:0] size;
  logic [PTR_WIDTH-1:0] head;
  logic [PTR_WIDTH-1:0] tail;
  logic [PTR_WIDTH-1:0] nsize;
  logic [PTR_WIDTH-1:0] nhead;
  logic [PTR_WIDTH-1:0] ntail;
  logic [PTR_WIDTH:0]   tail_inc;
  logic                 val_range;

  assign is_cq = kind_i[0];
  assign {size, head, tail} = is_cq ? cq_entry_i : sq_entry_i;
  assign tail_inc  = {1'b0, tail} + (PTR_WIDTH+1)'(1);
  assign val_range = value_i >= 16'(size);

  always_comb begin
    slot_ok = id_ok_i;
    if (kind_i != nqpt_pkg::KIND_CREATE_SQ && kind_i != nqpt_pkg::KIND_CREATE_CQ) begin
      slot_ok = id_ok_i && (is_cq ? cq_valid_i : sq_valid_i);
    end
  end

  always_comb begin
    upd_o       = '0;
    upd_o.is_cq = is_cq;
    nsize       = size;
    nhead       = head;
    ntail       = tail;
    nphase      = phase_i;
    report      = 1'b1;
    res_o       = '0;
    res_o.status = slot_ok ? nqpt_pkg::STATUS_OK : nqpt_pkg::STATUS_BAD_ID;

    if (slot_ok) begin
      unique case (kind_i) inside
        nqpt_pkg::KIND_CREATE_SQ, nqpt_pkg::KIND_CREATE_CQ: begin
          nsize           = value_i[PTR_WIDTH-1:0];
          nhead           = '0;
          ntail           = '0;
          upd_o.entry_wr  = 1'b1;
          upd_o.valid_set = 1'b1;
          if (is_cq) begin
            nphase          = 1'b1;
            upd_o.phase_wr  = 1'b1;
            upd_o.phase_val = 1'b1;
          end
        end
        nqpt_pkg::KIND_DELETE_SQ, nqpt_pkg::KIND_DELETE_CQ: begin
          upd_o.valid_clr = 1'b1;
          report          = 1'b0;
        end
        nqpt_pkg::KIND_SQ_DBELL: begin
          if (val_range) begin
            res_o.status = nqpt_pkg::STATUS_RANGE;
          end else begin
            ntail          = value_i[PTR_WIDTH-1:0];
            upd_o.entry_wr = 1'b1;
          end
        end
        nqpt_pkg::KIND_CQ_DBELL: begin
          if (val_range) begin
            res_o.status = nqpt_pkg::STATUS_RANGE;
          end else begin
            nhead          = value_i[PTR_WIDTH-1:0];
            upd_o.entry_wr = 1'b1;
          end
        end
        nqpt_pkg::KIND_SQ_ADV: begin
          nhead          = next_ptr(head, size);
          upd_o.entry_wr = 1'b1;
        end
        nqpt_pkg::KIND_CQ_POST: begin
          upd_o.entry_wr = 1'b1;
          // The tail wraps at the queue size and the phase tag flips with it.
          if (tail_inc >= {1'b0, size}) begin
            ntail           = '0;
            nphase          = ~phase_i;
            upd_o.phase_wr  = 1'b1;
            upd_o.phase_val = ~phase_i;
          end else begin
            ntail = tail_inc[PTR_WIDTH-1:0];
          end
        end
        default: begin
          report = 1'b0;
        end
      endcase

      if (report) begin
        res_o.head = 16'(nhead);
        res_o.tail = 16'(ntail);
        if (is_cq) begin
          res_o.cq_full = (next_ptr(ntail, nsize) == nhead);
          res_o.phase   = nphase;
        end else begin
          res_o.sq_empty = (nhead == ntail);
        end
      end
    end
  end

  assign entry_o = {nsize, nhead, ntail};

endmodule
